// ===== design/swmf_pkg.sv =====
// Shared types and constants for the sliding-window min/max line filter.
// No dependencies; imported by every module of the block.
package swmf_pkg;

    localparam int DEF_MAX_HALF   = 31;
    localparam int DEF_PIXEL_BITS = 8;

    localparam int HALF_W   = 5;     // half_width register width
    localparam int SEEN_W   = 6;     // pixels-in-line counter width
    localparam int OUT_W    = 8;     // filtered result width
    localparam int APB_AW   = 3;     // two registers at byte addresses 0 and 4
    localparam int APB_DW   = 32;
    localparam int OQ_DEPTH = 3;     // output queue entries
    localparam int OCC_W    = 2;

    localparam logic [HALF_W-1:0] HALF_RESET = 5'd4;
    localparam logic [SEEN_W-1:0] SEEN_MAX   = 6'd63;

    typedef enum logic [0:0] {
        REG_HALF_WIDTH = 1'b0,
        REG_MODE_MAX   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [OUT_W-1:0] filtered;
        logic             line_done;
    } t_result;

    typedef struct packed {
        logic adv;        // a pixel beat enters the chain
        logic first;      // the beat is the first pixel of a line
        logic last;       // the beat closes the line: capture snapshot
        logic mode_max;
    } t_cell_ctrl;

    typedef struct packed {
        logic [OCC_W-1:0] occ;
        logic             room;   // an entry can be pushed this cycle
    } t_oq_stat;

endpackage

// ===== design/swmf_cell.sv =====
// One cell of the running min/max chain: cell j holds the min and max over
// the newest j+1 pixels of the current line. Depends on swmf_pkg.
module swmf_cell import swmf_pkg::*; #(
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [PIXEL_BITS-1:0] i_pixel,
    input  logic [PIXEL_BITS-1:0] i_prev_min,
    input  logic [PIXEL_BITS-1:0] i_prev_max,
    output logic [PIXEL_BITS-1:0] o_min,
    output logic [PIXEL_BITS-1:0] o_max,
    output logic [PIXEL_BITS-1:0] o_snap
);

    logic [PIXEL_BITS-1:0] r_min;
    logic [PIXEL_BITS-1:0] r_max;
    logic [PIXEL_BITS-1:0] r_snap;
    logic [PIXEL_BITS-1:0] n_min;
    logic [PIXEL_BITS-1:0] n_max;

    // On the first pixel of a line the older cells hold nothing of this line.
    always_comb begin
        if (i_ctrl.first) begin
            n_min = i_pixel;
            n_max = i_pixel;
        end else begin
            n_min = (i_pixel < i_prev_min) ? i_pixel : i_prev_min;
            n_max = (i_pixel > i_prev_max) ? i_pixel : i_prev_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_min <= n_min;
            r_max <= n_max;
            if (i_ctrl.last) begin
                r_snap <= i_ctrl.mode_max ? n_max : n_min;
            end
        end
    end

    assign o_min  = r_min;
    assign o_max  = r_max;
    assign o_snap = r_snap;

endmodule

// ===== design/swmf_outq.sv =====
// Three-entry result queue in front of the output channel; head at entry 0.
// Depends on swmf_pkg for t_result and the queue sizing.
module swmf_outq import swmf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_result  i_data,
    input  logic     i_stall,
    output logic     o_valid,
    output t_result  o_data,
    output t_oq_stat o_stat
);

    t_result          r_q [OQ_DEPTH];
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic [OCC_W-1:0] wr_idx;
    logic             pop;

    assign pop    = (r_occ != '0) && !i_stall;
    assign wr_idx = r_occ - OCC_W'(pop);
    assign n_occ  = r_occ + OCC_W'(i_push) - OCC_W'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // Advance the queue on a pop; the new beat lands behind the last kept entry.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < OQ_DEPTH - 1; i++) begin
            if (i_push && (wr_idx == OCC_W'(i))) begin
                r_q[i] <= i_data;
            end else if (pop) begin
                r_q[i] <= r_q[i+1];
            end
        end
        if (i_push && (wr_idx == OCC_W'(OQ_DEPTH - 1))) begin
            r_q[OQ_DEPTH-1] <= i_data;
        end
    end

    assign o_valid     = (r_occ != '0);
    assign o_data      = r_q[0];
    assign o_stat.occ  = r_occ;
    assign o_stat.room = (r_occ < OCC_W'(OQ_DEPTH)) || pop;

endmodule

// ===== design/sliding_window_min_filter_1d_unit.sv =====
// Top level of the 1-D sliding-window min/max line filter: APB registers,
// cell chain, line-end flush sequencer. Depends on swmf_pkg, swmf_cell, swmf_outq.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------
//  pixel in | input     | i_valid / o_stall  | i_pixel, i_line_end
//  result   | output    | o_valid / i_stall  | o_filtered, o_line_done
//  config   | input     | APB psel / penable | paddr, pwdata, prdata
//
// One pixel beat per cycle while o_stall is low; its result leaves the chain in
// the next cycle into a three-entry queue. A line-end beat starts a flush of
// min(pixels before it, half_width)+1 results, one per cycle from cell snapshots
// while the queue has room and no result is pending; next-line pixels keep
// entering until one would give a result or close a line before the flush ends.
// Synchronous active-low reset; no clearing pass. A full queue holds o_stall.
module sliding_window_min_filter_1d_unit import swmf_pkg::*; #(
    parameter int MAX_HALF   = DEF_MAX_HALF,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_pixel,
    input  logic              i_line_end,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_filtered,
    output logic              o_line_done,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int NCELL = 2 * MAX_HALF + 1;
    localparam int IDXW  = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam logic [HALF_W-1:0] MAX_H = HALF_W'(MAX_HALF);

    // ---------------- configuration registers ----------------
    logic [HALF_W-1:0] r_half;
    logic              r_mode;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[APB_AW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RESET;
            r_mode <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HALF_WIDTH: r_half <= pwdata[HALF_W-1:0];
                REG_MODE_MAX:   r_mode <= pwdata[0];
                default:        r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HALF_WIDTH: prdata = {{(APB_DW-HALF_W){1'b0}}, r_half};
            REG_MODE_MAX:   prdata = {{(APB_DW-1){1'b0}}, r_mode};
            default:        prdata = '0;
        endcase
    end

    logic [HALF_W-1:0] half;
    assign half = (r_half > MAX_H) ? MAX_H : r_half;

    // ---------------- input side ----------------
    logic                  in_acc;
    logic [PIXEL_BITS-1:0] pix;
    logic [PIXEL_BITS+7:0] pix_wide;

    assign pix_wide = {{PIXEL_BITS{1'b0}}, i_pixel};
    assign pix      = pix_wide[PIXEL_BITS-1:0];
    assign in_acc   = i_valid && !o_stall;

    logic              r_first;
    logic [SEEN_W-1:0] r_seen;
    logic              seen_ge_h;
    logic [HALF_W-1:0] k_start;

    assign seen_ge_h = (r_seen >= {1'b0, half});
    assign k_start   = seen_ge_h ? half : r_seen[HALF_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_seen  <= '0;
        end else if (in_acc) begin
            r_first <= i_line_end;
            if (i_line_end) begin
                r_seen <= '0;
            end else if (r_seen != SEEN_MAX) begin
                r_seen <= r_seen + SEEN_W'(1);
            end
        end
    end

    // ---------------- cell chain ----------------
    t_cell_ctrl            cell_ctrl;
    logic [PIXEL_BITS-1:0] w_min  [NCELL];
    logic [PIXEL_BITS-1:0] w_max  [NCELL];
    logic [PIXEL_BITS-1:0] w_snap [NCELL];

    assign cell_ctrl.adv      = in_acc;
    assign cell_ctrl.first    = r_first;
    assign cell_ctrl.last     = i_line_end;
    assign cell_ctrl.mode_max = r_mode;

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        logic [PIXEL_BITS-1:0] prev_min;
        logic [PIXEL_BITS-1:0] prev_max;
        if (j == 0) begin : g_head
            assign prev_min = pix;
            assign prev_max = pix;
        end else begin : g_link
            assign prev_min = w_min[j-1];
            assign prev_max = w_max[j-1];
        end
        swmf_cell #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (cell_ctrl),
            .i_pixel    (pix),
            .i_prev_min (prev_min),
            .i_prev_max (prev_max),
            .o_min      (w_min[j]),
            .o_max      (w_max[j]),
            .o_snap     (w_snap[j])
        );
    end

    // ---------------- result sources ----------------
    logic              r_pend;
    logic [IDXW-1:0]   r_pend_idx;
    logic [SEEN_W-1:0] pend_sum;

    logic              r_fl_active;
    logic [HALF_W-1:0] r_fl_k;
    logic [HALF_W-1:0] r_fl_h;
    logic [SEEN_W-1:0] fl_sum;
    logic [IDXW-1:0]   fl_idx;
    logic              fl_go;

    t_oq_stat oq_stat;
    t_result  push_data;
    t_result  oq_data;
    logic     push;

    assign pend_sum = {half, 1'b0};
    assign fl_sum   = {1'b0, r_fl_k} + {1'b0, r_fl_h};
    assign fl_idx   = fl_sum[IDXW-1:0];
    assign fl_go    = r_fl_active && !r_pend && oq_stat.room;
    assign push     = r_pend || fl_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= in_acc && !i_line_end && seen_ge_h;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= pend_sum[IDXW-1:0];
    end

    // Flush sequencer: walk the centers of the closed line from oldest to newest.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl_active <= 1'b0;
        end else if (in_acc && i_line_end) begin
            r_fl_active <= 1'b1;
        end else if (fl_go && (r_fl_k == '0)) begin
            r_fl_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_line_end) begin
            r_fl_k <= k_start;
            r_fl_h <= half;
        end else if (fl_go) begin
            r_fl_k <= r_fl_k - HALF_W'(1);
        end
    end

    logic [PIXEL_BITS-1:0] sel_val;
    logic [PIXEL_BITS+7:0] sel_wide;

    always_comb begin
        if (r_pend) begin
            sel_val = r_mode ? w_max[r_pend_idx] : w_min[r_pend_idx];
        end else begin
            sel_val = w_snap[fl_idx];
        end
    end

    assign sel_wide            = {8'b0, sel_val};
    assign push_data.filtered  = sel_wide[OUT_W-1:0];
    assign push_data.line_done = !r_pend && (r_fl_k == '0);

    swmf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (oq_data),
        .o_stat  (oq_stat)
    );

    assign o_filtered  = oq_data.filtered;
    assign o_line_done = oq_data.line_done;

    // ---------------- input stall ----------------
    // Hold when the queue could not take this cycle's push plus next cycle's
    // result, or when a new beat would overtake a running flush.
    logic [OCC_W:0] occ_sum;
    logic           stall_q;
    logic           stall_fl;

    assign occ_sum  = {1'b0, oq_stat.occ} + {{OCC_W{1'b0}}, (r_pend || r_fl_active)};
    assign stall_q  = (occ_sum >= (OCC_W+1)'(OQ_DEPTH));
    assign stall_fl = r_fl_active && (i_line_end || seen_ge_h);
    assign o_stall  = stall_q || stall_fl;

endmodule

// ===== design/swmf_chk.sv =====
// Port-level checker for the sliding-window min/max filter, bound to the top.
// Depends on swmf_pkg for register indexes.
module swmf_chk import swmf_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              i_line_end,
    input logic              o_valid,
    input logic              i_stall,
    input logic [OUT_W-1:0]  o_filtered,
    input logic              o_line_done,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_filtered) && $stable(o_line_done))
        else $error("result beat changed while stalled");

    // Reset empties the queue and frees the input.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    // A line end right after a line end waits for the flush.
    a_flush_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_line_end) ##1 (i_valid && i_line_end) |-> o_stall)
        else $error("line end accepted during flush");

    // half_width reads back what was written.
    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && (paddr[APB_AW-1] == REG_HALF_WIDTH))
        ##1 (paddr[APB_AW-1] == REG_HALF_WIDTH)
        |-> prdata[HALF_W-1:0] == $past(pwdata[HALF_W-1:0]))
        else $error("half_width readback mismatch");

endmodule

bind sliding_window_min_filter_1d_unit swmf_chk u_swmf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_line_end  (i_line_end),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_filtered  (o_filtered),
    .o_line_done (o_line_done),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
);
